### rtl/mrrc_pkg.sv
// Package for the Modbus RTU response checker.
// Holds the status codes, the inter-module structs and the CRC-16/MODBUS byte update.
// No dependencies.
package mrrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLD  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT = 8'd4;
  localparam logic [7:0] FC_WRITE_MULT = 8'd16;

  typedef enum logic [2:0] {
    ST_READ  = 3'd0,
    ST_WACK  = 3'd1,
    ST_OTHER = 3'd2,
    ST_CRC   = 3'd3,
    ST_SHORT = 3'd4,
    ST_LONG  = 3'd5,
    ST_COUNT = 3'd6
  } status_t;

  // accepted input beat, as seen by the state-holding modules
  typedef struct packed {
    logic       accept;
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  // byte leaving the delay line into the CRC
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } crc_feed_t;

  // frame state after the current beat, for the end-of-frame verdict
  typedef struct packed {
    logic        overflow;
    logic        too_short;
    logic        count_over;
    logic [7:0]  func;
    logic [7:0]  tail0;
    logic [7:0]  tail1;
    logic [31:0] data_acc;
  } frame_info_t;

  // bitwise CRC-16/MODBUS over one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/mrrc_if.sv
// Valid/ready channel interfaces for the Modbus RTU response checker.
// Depends on nothing but the payload widths of the frame byte and the result.
interface mrrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value;
  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

### rtl/mrrc_crc.sv
// CRC-16/MODBUS accumulator for the response checker.
// Uses mrrc_pkg (beat and feed structs, byte update function).
module mrrc_crc (
  input  logic                clk,
  input  logic                rst_n,
  input  mrrc_pkg::beat_t     beat,
  input  mrrc_pkg::crc_feed_t feed,
  output logic [15:0]         crc_nxt
);

  logic [15:0] crc_r;

  assign crc_nxt = feed.en ? mrrc_pkg::crc_byte(crc_r, feed.data) : crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrrc_pkg::CRC_INIT;
    end else if (beat.accept) begin
      crc_r <= beat.last_byte ? mrrc_pkg::CRC_INIT : crc_nxt;
    end
  end

endmodule

### rtl/mrrc_frame.sv
// Frame tracker: byte position, two-byte tail delay line, header fields, data assembly.
// Uses mrrc_pkg (beat, feed and frame info structs).
module mrrc_frame #(
  parameter int MAX_FRAME = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mrrc_pkg::beat_t       beat,
  output mrrc_pkg::crc_feed_t   feed,
  output mrrc_pkg::frame_info_t info
);

  localparam int PW = $clog2(MAX_FRAME + 2);
  localparam int CW = ((PW > 8) ? PW : 8) + 1;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    tail0_r, tail1_r;
  logic [7:0]    func_r, func_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [31:0]   data_r, data_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] pos_ext, len_ext, cnt_ext;
  logic          take;

  always_comb begin
    pos_ext  = CW'(pos_r);
    pos_nxt  = (pos_r < PW'(MAX_FRAME + 1)) ? pos_r + 1'b1 : pos_r;
    len_ext  = CW'(pos_nxt);
    ovf_nxt  = ovf_r | (len_ext > CW'(MAX_FRAME));
    func_nxt = (pos_r == PW'(1)) ? beat.data_byte : func_r;
    cnt_nxt  = (pos_r == PW'(2)) ? beat.data_byte : cnt_r;
    cnt_ext  = CW'(cnt_r);
    // data byte while inside the declared count
    take     = (pos_ext >= CW'(3)) && (pos_ext < cnt_ext + CW'(3));
    data_nxt = take ? {data_r[23:0], beat.data_byte} : data_r;

    feed.en   = (pos_r >= PW'(2));
    feed.data = tail0_r;

    info.overflow   = ovf_nxt;
    info.too_short  = (len_ext < CW'(6));
    info.count_over = (CW'(cnt_nxt) + CW'(5)) > len_ext;
    info.func       = func_nxt;
    info.tail0      = tail1_r;
    info.tail1      = beat.data_byte;
    info.data_acc   = data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      tail0_r <= '0;
      tail1_r <= '0;
      func_r  <= '0;
      cnt_r   <= '0;
      data_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (beat.accept) begin
      if (beat.last_byte) begin
        pos_r   <= '0;
        tail0_r <= '0;
        tail1_r <= '0;
        func_r  <= '0;
        cnt_r   <= '0;
        data_r  <= '0;
        ovf_r   <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        tail0_r <= tail1_r;
        tail1_r <= beat.data_byte;
        func_r  <= func_nxt;
        cnt_r   <= cnt_nxt;
        data_r  <= data_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

endmodule

### rtl/modbus_rtu_response_checker.sv
// Modbus RTU response checker, top level.
// Uses mrrc_pkg, mrrc_if (channels), mrrc_crc and mrrc_frame.
//
// Usage:
//   in_ch  : one frame byte per beat (data_byte), last_byte high on the final byte.
//   out_ch : one result beat per frame (status, value), issued on the last byte.
//   Status: read data, write ack, other function, CRC error, too short,
//   too long, count overrun. value carries the big-endian data (low 32 bits)
//   for read data, 1 for write ack, 0 otherwise.
//   The CRC runs over all bytes but the last two, fed from a two-byte delay
//   line, and is compared low byte first against the trailing pair.
// Timing:
//   One byte accepted per cycle while no stalled result blocks in_ch. The result of a frame appears
//   in the cycle after its last byte is taken, from the output register.
//   The critical path is the eight-step CRC byte update plus the compare.
// Reset (rst_n low, synchronous): CRC to FFFF, frame state cleared, no
//   result pending. State also returns to reset after every last byte.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready drops;
//   bytes keep flowing whenever the output register is empty or draining.
module modbus_rtu_response_checker #(
  parameter int MAX_FRAME = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mrrc_in_if.sink    in_ch,
  mrrc_out_if.source out_ch
);

  mrrc_pkg::beat_t       beat;
  mrrc_pkg::crc_feed_t   feed;
  mrrc_pkg::frame_info_t info;
  logic [15:0]           crc_nxt;

  logic                  out_valid_r;
  mrrc_pkg::status_t     status_r, status_nxt;
  logic [31:0]           value_r, value_nxt;
  logic                  in_ready;

  // output register frees up in the same cycle it drains
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;

  assign beat.accept    = in_ch.valid && in_ready;
  assign beat.data_byte = in_ch.data_byte;
  assign beat.last_byte = in_ch.last_byte;

  mrrc_crc u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .feed    (feed),
    .crc_nxt (crc_nxt)
  );

  mrrc_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (beat),
    .feed  (feed),
    .info  (info)
  );

  // verdict, in priority order: too long, too short, CRC, function decode
  always_comb begin
    value_nxt = '0;
    if (info.overflow) begin
      status_nxt = mrrc_pkg::ST_LONG;
    end else if (info.too_short) begin
      status_nxt = mrrc_pkg::ST_SHORT;
    end else if ((info.tail0 != crc_nxt[7:0]) || (info.tail1 != crc_nxt[15:8])) begin
      status_nxt = mrrc_pkg::ST_CRC;
    end else if ((info.func == mrrc_pkg::FC_READ_HOLD) ||
                 (info.func == mrrc_pkg::FC_READ_INPUT)) begin
      if (info.count_over) begin
        status_nxt = mrrc_pkg::ST_COUNT;
      end else begin
        status_nxt = mrrc_pkg::ST_READ;
        value_nxt  = info.data_acc;
      end
    end else if (info.func == mrrc_pkg::FC_WRITE_MULT) begin
      status_nxt = mrrc_pkg::ST_WACK;
      value_nxt  = 32'd1;
    end else begin
      status_nxt = mrrc_pkg::ST_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat.accept && beat.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (beat.accept && beat.last_byte) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.value  = value_r;

endmodule
